/* rtl/jhds_pkg.sv */
// jhds_pkg: marker codes and widths for the jpeg frame-header dimension scanner
// no dependencies; used by jpeg_header_dimension_scan
`timescale 1ns / 1ps
`default_nettype none

package jhds_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int SEG_BITS        = 16;
  localparam int DIM_BITS        = 16;

  localparam logic [7:0] MK_FILL = 8'hFF;
  localparam logic [7:0] MK_SOI  = 8'hD8;
  localparam logic [7:0] MK_EOI  = 8'hD9;
  localparam logic [7:0] MK_SOS  = 8'hDA;

  localparam logic [SEG_BITS-1:0] OFF_HEIGHT_HI = 16'd3;
  localparam logic [SEG_BITS-1:0] OFF_HEIGHT_LO = 16'd4;
  localparam logic [SEG_BITS-1:0] OFF_WIDTH_HI  = 16'd5;
  localparam logic [SEG_BITS-1:0] OFF_WIDTH_LO  = 16'd6;
  localparam logic [SEG_BITS-1:0] SEG_MIN_LEN   = 16'd2;
  localparam logic [SEG_BITS-1:0] SOF_MIN_LEN   = 16'd7;

  // start-of-frame markers: c0-c3, c5-c7, c9-cb, cd-cf
  function automatic logic is_frame_marker(input logic [7:0] m);
    logic r;
    r = (m >= 8'hC0 && m <= 8'hC3) || (m >= 8'hC5 && m <= 8'hC7) ||
        (m >= 8'hC9 && m <= 8'hCB) || (m >= 8'hCD && m <= 8'hCF);
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/jpeg_header_dimension_scan.sv */
// jpeg_header_dimension_scan: byte-serial jpeg marker walker that reports frame size
// depends on jhds_pkg
//
//  channel | ports                                              | direction
//  in      | in_valid/in_ready, data_byte, buffer_start, length | request in, one byte each
//  out     | out_valid/out_ready, found, image_width, height    | request out, at most one per buffer
//
// one byte per cycle; each byte is decoded combinationally into the state and
// result registers, so a new byte is taken every cycle while the result slot is free
// or being drained in the same cycle
// reset (rst_n low, synchronous) returns to idle with no buffer open
// a stalled result holds the input only when the result register is full
`timescale 1ns / 1ps
`default_nettype none

module jpeg_header_dimension_scan #(
  parameter int LENGTH_BITS = jhds_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                in_data_byte,
  input  wire logic                      in_buffer_start,
  input  wire logic [LENGTH_BITS-1:0]    in_buffer_length,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_found,
  output logic [jhds_pkg::DIM_BITS-1:0]  out_image_width,
  output logic [jhds_pkg::DIM_BITS-1:0]  out_image_height
);

  localparam int LW = LENGTH_BITS;
  localparam int SB = jhds_pkg::SEG_BITS;
  localparam int DB = jhds_pkg::DIM_BITS;
  localparam int XW = LW + SB + 1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SOI1, PH_SCAN, PH_FFRUN, PH_LENHI, PH_LENLO, PH_SKIP, PH_FRAME, PH_FAIL
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [LW-1:0]   pos_r, pos_nxt;
  logic [SB-1:0]   seg_len_r, seg_len_nxt;
  logic [SB-1:0]   seg_off_r, seg_off_nxt;
  logic            is_frame_r, is_frame_nxt;
  logic [DB-1:0]   height_r, height_nxt;
  logic [7:0]      width_hi_r, width_hi_nxt;
  logic            given_r, given_nxt;

  logic            out_valid_r;
  logic            out_found_r;
  logic [DB-1:0]   out_width_r, out_height_r;

  logic            accept;
  logic            emit, emit_found, tail;
  logic [DB-1:0]   emit_width, emit_height;
  logic [LW-1:0]   p;
  logic [7:0]      b;
  logic [SB-1:0]   seg_full;
  logic [SB-1:0]   off_inc;
  logic [LW+1:0]   p_ext, len_ext;
  logic [XW-1:0]   seg_end, len_wide;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign b        = in_data_byte;
  assign p        = in_buffer_start ? '0 : pos_r;
  assign p_ext    = {2'b00, p};
  assign len_ext  = {2'b00, in_buffer_length};
  assign seg_full = {seg_len_r[SB-1:8], b};
  assign off_inc  = seg_off_r + 1'b1;
  assign seg_end  = {{(SB+1){1'b0}}, p} - {{(XW-1){1'b0}}, 1'b1} + {{(LW+1){1'b0}}, seg_full};
  assign len_wide = {{(SB+1){1'b0}}, in_buffer_length};

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    seg_len_nxt  = seg_len_r;
    seg_off_nxt  = seg_off_r;
    is_frame_nxt = is_frame_r;
    height_nxt   = height_r;
    width_hi_nxt = width_hi_r;
    given_nxt    = given_r;
    emit         = 1'b0;
    emit_found   = 1'b0;
    emit_width   = '0;
    emit_height  = '0;
    tail         = 1'b0;
    if (accept) begin
      if (in_buffer_start) begin
        given_nxt    = 1'b0;
        is_frame_nxt = 1'b0;
        seg_len_nxt  = '0;
        seg_off_nxt  = '0;
        tail         = 1'b1;
        phase_nxt    = (len_ext < (LW+2)'(4) || b != jhds_pkg::MK_FILL) ? PH_FAIL : PH_SOI1;
      end else if (!given_r) begin
        tail = 1'b1;
        case (phase_r)
          PH_SOI1: begin
            phase_nxt = (b == jhds_pkg::MK_SOI) ? PH_SCAN : PH_FAIL;
          end
          PH_SCAN: begin
            if (p_ext + (LW+2)'(3) >= len_ext) phase_nxt = PH_FAIL;
            else if (b == jhds_pkg::MK_FILL) phase_nxt = PH_FFRUN;
          end
          PH_FFRUN: begin
            if (b != jhds_pkg::MK_FILL) begin
              if (b == jhds_pkg::MK_EOI || b == jhds_pkg::MK_SOS ||
                  p_ext + (LW+2)'(2) >= len_ext) begin
                phase_nxt = PH_FAIL;
              end else begin
                is_frame_nxt = jhds_pkg::is_frame_marker(b);
                phase_nxt    = PH_LENHI;
              end
            end
          end
          PH_LENHI: begin
            seg_len_nxt = {b, 8'h00};
            phase_nxt   = PH_LENLO;
          end
          PH_LENLO: begin
            seg_len_nxt = seg_full;
            seg_off_nxt = jhds_pkg::SEG_MIN_LEN;
            if (seg_full < jhds_pkg::SEG_MIN_LEN || seg_end > len_wide) phase_nxt = PH_FAIL;
            else if (is_frame_r && seg_full >= jhds_pkg::SOF_MIN_LEN) phase_nxt = PH_FRAME;
            else if (seg_full == jhds_pkg::SEG_MIN_LEN) phase_nxt = PH_SCAN;
            else phase_nxt = PH_SKIP;
          end
          PH_SKIP: begin
            seg_off_nxt = off_inc;
            if (off_inc == seg_len_r) phase_nxt = PH_SCAN;
          end
          PH_FRAME: begin
            seg_off_nxt = off_inc;
            if (seg_off_r == jhds_pkg::OFF_HEIGHT_HI) height_nxt = {b, 8'h00};
            else if (seg_off_r == jhds_pkg::OFF_HEIGHT_LO) height_nxt = {height_r[DB-1:8], b};
            else if (seg_off_r == jhds_pkg::OFF_WIDTH_HI) width_hi_nxt = b;
            else if (seg_off_r == jhds_pkg::OFF_WIDTH_LO) begin
              if ({width_hi_r, b} != '0 && height_r != '0) begin
                tail        = 1'b0;
                emit        = 1'b1;
                emit_found  = 1'b1;
                emit_width  = {width_hi_r, b};
                emit_height = height_r;
                given_nxt   = 1'b1;
                phase_nxt   = PH_IDLE;
                pos_nxt     = p + 1'b1;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (tail) begin
        pos_nxt = p + 1'b1;
        if ({1'b0, p} + (LW+1)'(1) >= {1'b0, in_buffer_length}) begin
          emit      = 1'b1;
          given_nxt = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pos_r        <= '0;
      given_r      <= 1'b1;
      is_frame_r   <= 1'b0;
      seg_len_r    <= '0;
      seg_off_r    <= '0;
      height_r     <= '0;
      width_hi_r   <= '0;
      out_valid_r  <= 1'b0;
      out_found_r  <= 1'b0;
      out_width_r  <= '0;
      out_height_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      given_r    <= given_nxt;
      is_frame_r <= is_frame_nxt;
      seg_len_r  <= seg_len_nxt;
      seg_off_r  <= seg_off_nxt;
      height_r   <= height_nxt;
      width_hi_r <= width_hi_nxt;
      if (emit) begin
        out_valid_r  <= 1'b1;
        out_found_r  <= emit_found;
        out_width_r  <= emit_width;
        out_height_r <= emit_height;
      end else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_image_width  = out_width_r;
  assign out_image_height = out_height_r;

  a_found_dims: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_image_width != '0 && out_image_height != '0)
    else $error("found result with zero dimension");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_image_width == '0 && out_image_height == '0)
    else $error("failure result with nonzero dimension");

  a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> given_r && phase_r == PH_IDLE)
    else $error("buffer still open after its result");

  a_open_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !given_r |-> phase_r != PH_IDLE)
    else $error("open buffer in idle phase");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// testbench for jpeg_header_dimension_scan: streams jpeg-like byte buffers and checks
// each reported frame size against a byte-level predictor of the marker walk
// depends on jhds_pkg and the rtl top level
`timescale 1ns / 1ps

module testbench;

  localparam int LB = jhds_pkg::LENGTH_BITS_DEF;
  localparam int unsigned MAX_LEN = (1 << LB) - 1;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [3:0] {
    WALK_IDLE, WALK_SOI, WALK_SEEK, WALK_FILL, WALK_LEN_HI, WALK_LEN_LO,
    WALK_SKIP, WALK_FRAME, WALK_FAIL
  } walk_state_t;

  typedef struct packed {
    logic                          found;
    logic [jhds_pkg::DIM_BITS-1:0] width;
    logic [jhds_pkg::DIM_BITS-1:0] height;
  } dims_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_data_byte = 8'h00;
  logic                          in_buffer_start = 1'b0;
  logic [LB-1:0]                 in_buffer_length = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_found;
  logic [jhds_pkg::DIM_BITS-1:0] out_image_width;
  logic [jhds_pkg::DIM_BITS-1:0] out_image_height;

  // walker state of the predictor
  walk_state_t                   walk_state = WALK_IDLE;
  logic [LB-1:0]                 walk_pos = '0;
  logic [jhds_pkg::SEG_BITS-1:0] seg_len = '0;
  logic [jhds_pkg::SEG_BITS-1:0] seg_off = '0;
  logic                          seg_is_frame = 1'b0;
  logic [jhds_pkg::DIM_BITS-1:0] height_acc = '0;
  logic [jhds_pkg::DIM_BITS-1:0] width_acc = '0;
  logic                          buffer_open = 1'b0;

  dims_t      expected_dims[$];
  dims_t      dims_head;
  logic [7:0] img[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         bytes_sent = 0;
  int         results_seen = 0;
  int         fail_count = 0;
  int         cycle_count = 0;

  jpeg_header_dimension_scan #(.LENGTH_BITS(LB)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_buffer_start  (in_buffer_start),
    .in_buffer_length (in_buffer_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_dims.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: found=%0d width=%0d height=%0d",
                   out_found, out_image_width, out_image_height);
      end else begin
        dims_head = expected_dims.pop_front();
        if (dims_head.found !== out_found || dims_head.width !== out_image_width ||
            dims_head.height !== out_image_height) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected found=%0d width=%0d height=%0d, got %0d %0d %0d",
                     dims_head.found, dims_head.width, dims_head.height,
                     out_found, out_image_width, out_image_height);
        end
      end
    end
  end

  // start-of-frame codes: c0..cf except c4, c8, cc
  function automatic bit frame_code(input logic [7:0] m);
    return m[7:4] == 4'hC && !(m[1:0] == 2'b00 && m[3:2] != 2'b00);
  endfunction

  function automatic bit predict_dims(input logic [7:0] b, input logic start,
                                      input logic [LB-1:0] len, output dims_t r);
    logic [31:0] p;
    logic [31:0] ln;
    ln = 32'(len);
    r = '0;
    if (start) begin
      seg_len = '0;
      seg_off = '0;
      seg_is_frame = 1'b0;
      height_acc = '0;
      width_acc = '0;
      buffer_open = 1'b1;
      p = 32'd0;
      walk_state = (ln < 32'd4 || b != jhds_pkg::MK_FILL) ? WALK_FAIL : WALK_SOI;
    end else begin
      if (!buffer_open) return 1'b0;
      p = 32'(walk_pos);
      case (walk_state)
        WALK_SOI: walk_state = (b == jhds_pkg::MK_SOI) ? WALK_SEEK : WALK_FAIL;
        WALK_SEEK: begin
          if (p + 32'd3 >= ln) walk_state = WALK_FAIL;
          else if (b == jhds_pkg::MK_FILL) walk_state = WALK_FILL;
        end
        WALK_FILL: begin
          if (b != jhds_pkg::MK_FILL) begin
            if (b == jhds_pkg::MK_EOI || b == jhds_pkg::MK_SOS || p + 32'd2 >= ln) begin
              walk_state = WALK_FAIL;
            end else begin
              seg_is_frame = frame_code(b);
              walk_state = WALK_LEN_HI;
            end
          end
        end
        WALK_LEN_HI: begin
          seg_len = {b, 8'h00};
          walk_state = WALK_LEN_LO;
        end
        WALK_LEN_LO: begin
          seg_len[7:0] = b;
          seg_off = jhds_pkg::SEG_MIN_LEN;
          if (seg_len < jhds_pkg::SEG_MIN_LEN || (p - 32'd1) + 32'(seg_len) > ln)
            walk_state = WALK_FAIL;
          else if (seg_is_frame && seg_len >= jhds_pkg::SOF_MIN_LEN)
            walk_state = WALK_FRAME;
          else if (seg_len == jhds_pkg::SEG_MIN_LEN)
            walk_state = WALK_SEEK;
          else
            walk_state = WALK_SKIP;
        end
        WALK_SKIP: begin
          seg_off = seg_off + 1'b1;
          if (seg_off == seg_len) walk_state = WALK_SEEK;
        end
        WALK_FRAME: begin
          case (seg_off)
            jhds_pkg::OFF_HEIGHT_HI: height_acc = {b, 8'h00};
            jhds_pkg::OFF_HEIGHT_LO: height_acc[7:0] = b;
            jhds_pkg::OFF_WIDTH_HI:  width_acc = {b, 8'h00};
            jhds_pkg::OFF_WIDTH_LO: begin
              width_acc[7:0] = b;
              if (width_acc != '0 && height_acc != '0) begin
                r = '{found: 1'b1, width: width_acc, height: height_acc};
                buffer_open = 1'b0;
                walk_state = WALK_IDLE;
                walk_pos = LB'(p + 32'd1);
                return 1'b1;
              end
              walk_state = WALK_FAIL;
            end
            default: ;
          endcase
          seg_off = seg_off + 1'b1;
        end
        default: ;
      endcase
    end
    walk_pos = LB'(p + 32'd1);
    if (p + 32'd1 >= ln) begin
      buffer_open = 1'b0;
      walk_state = WALK_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic start, input logic [LB-1:0] len);
    dims_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_buffer_start <= start;
    in_buffer_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (predict_dims(b, start, len, r)) expected_dims.push_back(r);
  endtask

  task automatic send_image(input logic [LB-1:0] len);
    foreach (img[i]) send_byte(img[i], i == 0, len);
  endtask

  task automatic push_frame(input logic [7:0] mk, input logic [15:0] sl,
                            input logic [15:0] h, input logic [15:0] w);
    img.push_back(jhds_pkg::MK_FILL);
    img.push_back(mk);
    img.push_back(sl[15:8]);
    img.push_back(sl[7:0]);
    img.push_back(8'($urandom));
    img.push_back(h[15:8]);
    img.push_back(h[7:0]);
    img.push_back(w[15:8]);
    img.push_back(w[7:0]);
    repeat (int'(sl) - 7) img.push_back(8'($urandom));
  endtask

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic build_image(input bit allow_bad);
    logic [7:0] mk;
    int sl;
    img.delete();
    img.push_back(jhds_pkg::MK_FILL);
    img.push_back(jhds_pkg::MK_SOI);
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(3) == 0) img.push_back(8'($urandom_range(0, 254)));
      repeat (($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1)
        img.push_back(jhds_pkg::MK_FILL);
      mk = 8'($urandom_range(0, 254));
      sl = $urandom_range(2, 8);
      if (frame_code(mk)) sl = $urandom_range(2, 6);
      if (mk == jhds_pkg::MK_EOI || mk == jhds_pkg::MK_SOS) mk = 8'hE1;
      if (allow_bad && $urandom_range(5) == 0)
        mk = $urandom_range(1) ? jhds_pkg::MK_EOI : jhds_pkg::MK_SOS;
      if (allow_bad && $urandom_range(5) == 0)
        sl = $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(100, 65535);
      img.push_back(mk);
      img.push_back(8'(sl >> 8));
      img.push_back(8'(sl));
      repeat ((sl > 12) ? 6 : ((sl > 2) ? sl - 2 : 0)) img.push_back(8'($urandom));
    end
    if ($urandom_range(3) == 0) img.push_back(8'($urandom_range(0, 254)));
    mk = 8'hC0 | 8'($urandom_range(15));
    if (!frame_code(mk)) mk = mk ^ 8'h01;
    push_frame(mk, 16'($urandom_range(7, 10)), pick_dim(), pick_dim());
    repeat ($urandom_range(0, 4)) img.push_back(8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_dims.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic test_stray_bytes();
    send_byte(jhds_pkg::MK_FILL, 1'b0, LB'(5));
  endtask

  task automatic test_max_dimensions();
    img.delete();
    img.push_back(jhds_pkg::MK_FILL);
    img.push_back(jhds_pkg::MK_SOI);
    push_frame(8'hC0, jhds_pkg::SOF_MIN_LEN, 16'hFFFF, 16'hFFFF);
    send_image(LB'(MAX_LEN));
    // byte after the reported size is dropped
    send_byte(8'h00, 1'b0, LB'(MAX_LEN));
  endtask

  task automatic test_short_buffer();
    send_byte(jhds_pkg::MK_FILL, 1'b1, LB'(1));
  endtask

  task automatic test_scan_window();
    img.delete();
    img.push_back(jhds_pkg::MK_FILL);
    img.push_back(jhds_pkg::MK_SOI);
    img.push_back(jhds_pkg::MK_FILL);
    img.push_back(jhds_pkg::MK_EOI);
    send_image(LB'(4));
  endtask

  task automatic test_early_restart();
    send_byte(jhds_pkg::MK_FILL, 1'b1, LB'(100));
    send_byte(jhds_pkg::MK_SOI, 1'b0, LB'(100));
  endtask

  task automatic test_zero_dimension();
    img.delete();
    img.push_back(jhds_pkg::MK_FILL);
    img.push_back(jhds_pkg::MK_SOI);
    push_frame(8'hCF, jhds_pkg::SOF_MIN_LEN, 16'h0000, 16'h1234);
    send_image(LB'(img.size()));
  endtask

  task automatic test_random_traffic(input int n_bytes, input int min_results);
    int stop_bytes;
    int stop_results;
    int kind;
    int cut;
    logic [LB-1:0] len;
    stop_bytes = bytes_sent + n_bytes;
    stop_results = results_seen + min_results;
    while (bytes_sent < stop_bytes || results_seen < stop_results) begin
      kind = $urandom_range(99);
      build_image(kind >= 70);
      len = LB'(img.size());
      if (kind >= 70) begin
        case ($urandom_range(4))
          0: img[$urandom_range(img.size() - 1)] = 8'($urandom);
          1: len = LB'($urandom_range(1, img.size()));
          2: len = LB'($urandom_range(img.size(), MAX_LEN));
          3: begin
            // cut short so the next buffer restarts the parse
            cut = $urandom_range(1, img.size());
            while (img.size() > cut) void'(img.pop_back());
          end
          default: begin
            img.delete();
            repeat ($urandom_range(1, 12)) img.push_back(8'($urandom));
            if ($urandom_range(1)) img[0] = jhds_pkg::MK_FILL;
            len = LB'($urandom_range(1, 16));
          end
        endcase
      end else if ($urandom_range(9) == 0) begin
        len = LB'($urandom_range(img.size(), MAX_LEN));
      end
      send_image(len);
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, len);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(0, 0);
    test_stray_bytes();
    test_max_dimensions();
    test_short_buffer();
    test_scan_window();
    test_early_restart();
    test_zero_dimension();
    drain();
    test_random_traffic(250, 10);
    drain();
    set_idling(62, 0);
    test_random_traffic(250, 10);
    drain();
    set_idling(0, 62);
    test_random_traffic(250, 10);
    drain();
    set_idling(22, 22);
    test_random_traffic(250, 10);
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
